### sv/dtt_pkg.sv
// Shared types and constants of the delimited text tokenizer.
// No dependencies; imported by every module of the block.
package dtt_pkg;

    // result kinds
    localparam logic [2:0] KIND_CHAR  = 3'd0;
    localparam logic [2:0] KIND_NUM   = 3'd1;
    localparam logic [2:0] KIND_ALPHA = 3'd2;
    localparam logic [2:0] KIND_SEP   = 3'd3;
    localparam logic [2:0] KIND_EOL   = 3'd4;
    localparam logic [2:0] KIND_END   = 3'd5;

    // configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_DELIM  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SECOND_DELIM = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLLAPSE     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_NUMS_AS_TEXT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PLAIN_NUMS   = 3'd4;
    localparam int CFG_DATA_W = 8;

    // characters with special meaning
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_TOKEN  = 4'b0010,
        MODE_QUOTED = 4'b0100,
        MODE_RUN    = 4'b1000
    } mode_e_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] char_out;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] first_delimiter;
        logic [7:0] second_delimiter;
        logic       collapse_delimiters;
        logic       numbers_as_text;
        logic       plain_numbers_only;
    } cfg_t;

    typedef struct packed {
        mode_e_t mode;
        logic    still_numeric;
        logic    seen_digit;
        logic    ends_in_digit_part;
    } scan_state_t;

    // results of one item: count plus up to two items
    typedef struct packed {
        logic [1:0] n;
        out_item_t  r0;
        out_item_t  r1;
    } scan_res_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              space;
    } q_stat_t;

endpackage

### sv/dtt_scan.sv
// Per-byte decode of the tokenizer: results and next scanner state.
// Depends on dtt_pkg.
module dtt_scan
    import dtt_pkg::*;
(
    input  in_item_t    item,
    input  cfg_t        cfg,
    input  scan_state_t state,
    output scan_res_t   res,
    output scan_state_t state_next
);

    logic [7:0]  c;
    logic        is_nl, is_quote, is_delim, is_digit, is_sign, is_e, numeric;
    logic [2:0]  end_kind;
    logic        idle_has;
    logic [2:0]  idle_kind;
    scan_state_t idle_next;
    scan_state_t track_next;
    logic [2:0]  k0, k1;
    logic [1:0]  n;

    always_comb begin
        c        = item.text_byte;
        is_nl    = (c == CH_NL);
        is_quote = (c == CH_QUOTE);
        is_delim = (c == cfg.first_delimiter) ||
                   ((cfg.second_delimiter != 8'd0) && (c == cfg.second_delimiter));
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_sign  = (c == CH_MINUS) || (c == CH_PLUS);
        is_e     = (c == CH_LO_E) || (c == CH_UP_E);
        numeric  = is_digit || (c == CH_DOT) ||
                   (!cfg.plain_numbers_only && (is_sign || is_e));
        end_kind = (state.still_numeric && state.seen_digit && state.ends_in_digit_part)
                   ? KIND_NUM : KIND_ALPHA;

        // continuing an unquoted token
        track_next = state;
        if (!numeric) begin
            track_next.still_numeric = 1'b0;
        end else if (is_digit) begin
            track_next.seen_digit         = 1'b1;
            track_next.ends_in_digit_part = 1'b1;
        end else if (is_sign) begin
            track_next.ends_in_digit_part = 1'b0;
        end

        // byte seen between tokens
        idle_next = state;
        idle_has  = 1'b1;
        idle_kind = KIND_CHAR;
        if (is_nl) begin
            idle_next.mode = MODE_IDLE;
            idle_kind      = KIND_EOL;
        end else if (is_delim) begin
            idle_next.mode = cfg.collapse_delimiters ? MODE_RUN : MODE_IDLE;
            idle_kind      = KIND_SEP;
        end else if (is_quote) begin
            idle_next.mode = MODE_QUOTED;
            idle_has       = 1'b0;
        end else begin
            idle_next.mode               = MODE_TOKEN;
            idle_next.still_numeric      = !cfg.numbers_as_text && !is_e && numeric;
            idle_next.seen_digit         = is_digit;
            idle_next.ends_in_digit_part = is_digit;
        end

        state_next = state;
        k0 = KIND_END;
        k1 = KIND_END;
        n  = 2'd0;
        if (item.end_of_input) begin
            state_next.mode = MODE_IDLE;
            if (state.mode == MODE_TOKEN || state.mode == MODE_QUOTED) begin
                k0 = (state.mode == MODE_TOKEN) ? end_kind : KIND_ALPHA;
                k1 = KIND_END;
                n  = 2'd2;
            end else begin
                k0 = KIND_END;
                n  = 2'd1;
            end
        end else begin
            case (state.mode)
                MODE_TOKEN: begin
                    if (is_delim || is_nl) begin
                        // token end, then the delimiter or newline itself
                        k0         = end_kind;
                        k1         = idle_kind;
                        n          = 2'd2;
                        state_next = idle_next;
                    end else begin
                        k0         = KIND_CHAR;
                        n          = 2'd1;
                        state_next = track_next;
                    end
                end
                MODE_QUOTED: begin
                    if (is_quote) begin
                        state_next.mode = MODE_IDLE;
                        k0 = KIND_ALPHA;
                        n  = 2'd1;
                    end else if (is_nl) begin
                        state_next.mode = MODE_IDLE;
                        k0 = KIND_ALPHA;
                        k1 = KIND_EOL;
                        n  = 2'd2;
                    end else begin
                        k0 = KIND_CHAR;
                        n  = 2'd1;
                    end
                end
                MODE_RUN: begin
                    if (!is_delim) begin
                        state_next = idle_next;
                        k0 = idle_kind;
                        n  = {1'b0, idle_has};
                    end
                end
                default: begin
                    state_next = idle_next;
                    k0 = idle_kind;
                    n  = {1'b0, idle_has};
                end
            endcase
        end

        res.n           = n;
        res.r0.kind     = k0;
        res.r0.char_out = (k0 == KIND_CHAR) ? c : 8'd0;
        res.r0.last     = (n == 2'd1);
        res.r1.kind     = k1;
        res.r1.char_out = (k1 == KIND_CHAR) ? c : 8'd0;
        res.r1.last     = 1'b1;
    end

endmodule

### sv/dtt_rq.sv
// Result queue: takes up to two results per cycle, hands out one.
// Depends on dtt_pkg.
module dtt_rq
    import dtt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic [1:0] push_n,
    input  out_item_t push0,
    input  out_item_t push1,
    input  logic      pop,
    output out_item_t head,
    output q_stat_t   stat
);

    out_item_t         entries_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QPTR_W-1:0] wr_ptr_p1;

    assign wr_ptr_p1   = wr_ptr_reg + QPTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
    assign count_next  = count_reg + QCNT_W'(push_n) - QCNT_W'(pop);

    assign head       = entries_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.space = (count_reg <= QCNT_W'(QDEPTH - 2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            entries_reg[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            entries_reg[wr_ptr_p1] <= push1;
        end
    end

endmodule

### sv/delimited_text_tokenizer_top.sv
// Top level of the delimited text tokenizer: config registers, input register,
// scanner state and result queue. Depends on dtt_pkg, dtt_scan, dtt_rq.
//
//  port group   dir  handshake          payload
//  s_*          in   s_valid / s_ready  in_item_t  {text_byte, end_of_input}
//  m_*          out  m_valid / m_ready  out_item_t {kind, char_out, last}
//  cfg_*        in   cfg_wr_en          cfg_addr (register index), cfg_wdata
//
// An item is decoded from the input register once it has been accepted, and its
// zero to two results land in a four-entry queue, which offers them in order.
// One byte per cycle while items give one result and m_ready stays high; an item with
// two results needs the output port for each of them, bounded by the single-result output port.
// Decode waits while fewer than two queue slots are free; m_ready low stalls input
// once the input register and queue fill. Synchronous active-low reset.
module delimited_text_tokenizer_top
    import dtt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t        cfg_reg, cfg_next;
    logic        in_valid_reg, in_valid_next;
    in_item_t    in_data_reg;
    scan_state_t state_reg, state_next;
    scan_res_t   res;
    q_stat_t     q_stat;
    logic        advance;
    logic        pop;
    logic [1:0]  push_n;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_FIRST_DELIM:  cfg_next.first_delimiter     = cfg_wdata;
                CFG_SECOND_DELIM: cfg_next.second_delimiter    = cfg_wdata;
                CFG_COLLAPSE:     cfg_next.collapse_delimiters = cfg_wdata[0];
                CFG_NUMS_AS_TEXT: cfg_next.numbers_as_text     = cfg_wdata[0];
                CFG_PLAIN_NUMS:   cfg_next.plain_numbers_only  = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign advance       = in_valid_reg && q_stat.space;
    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !advance);
    assign push_n        = advance ? res.n : 2'd0;
    assign m_valid       = (q_stat.count != '0);
    assign pop           = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_delimiter     <= 8'd44;
            cfg_reg.second_delimiter    <= 8'd0;
            cfg_reg.collapse_delimiters <= 1'b0;
            cfg_reg.numbers_as_text     <= 1'b0;
            cfg_reg.plain_numbers_only  <= 1'b0;
            in_valid_reg                <= 1'b0;
            state_reg.mode               <= MODE_IDLE;
            state_reg.still_numeric      <= 1'b0;
            state_reg.seen_digit         <= 1'b0;
            state_reg.ends_in_digit_part <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            in_valid_reg <= in_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    dtt_scan u_scan (
        .item       (in_data_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .res        (res),
        .state_next (state_next)
    );

    dtt_rq u_rq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_n  (push_n),
        .push0   (res.r0),
        .push1   (res.r1),
        .pop     (pop),
        .head    (m_data),
        .stat    (q_stat)
    );

    // an end mark always produces an input-end result
    a_eoi_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_data_reg.end_of_input |=> m_valid)
        else $error("end of input produced no result");

    a_q_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_q_double: assert property (@(posedge aclk) disable iff (!aresetn)
        push_n == 2'd2 && !pop |=> q_stat.count == $past(q_stat.count) + QCNT_W'(2))
        else $error("double push lost a result");

endmodule

### dv/tb.sv
// Testbench for delimited_text_tokenizer_top: random CSV-style byte streams under
// several register settings, checked against an in-bench tokenizer predictor.
// Depends on dtt_pkg and the RTL of the block only.
module tb
    import dtt_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 160;
    localparam int MAX_REPORTS    = 20;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    delimited_text_tokenizer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // tokenizer predictor: register copies and scan state
    logic [7:0] delim_a      = 8'd44;
    logic [7:0] delim_b      = 8'd0;
    logic       collapse_en  = 1'b0;
    logic       text_only    = 1'b0;
    logic       plain_only   = 1'b0;
    mode_e_t    scan_mode    = MODE_IDLE;
    logic       still_numeric = 1'b0;
    logic       seen_digit   = 1'b0;
    logic       digit_tail   = 1'b0;

    out_item_t  step_res[$];
    out_item_t  expected_tokens[$];
    in_item_t   pending_bytes[$];

    int error_count  = 0;
    int in_count     = 0;
    int end_count    = 0;
    int out_count    = 0;
    int cfg_count    = 0;
    int idle_cycles  = 0;
    int gap_max      = 0;
    int stall_max    = 0;
    int gap_left     = 0;
    int burst_left   = 0;
    int ready_left   = 0;
    int stall_left   = 0;
    bit s_taken      = 1'b0;

    function automatic void emit(logic [2:0] kind, logic [7:0] ch);
        out_item_t r;
        r.kind     = kind;
        r.char_out = (kind == KIND_CHAR) ? ch : 8'd0;
        r.last     = 1'b0;
        step_res.push_back(r);
    endfunction

    function automatic logic is_delim(logic [7:0] c);
        return c == delim_a || (delim_b != 8'd0 && c == delim_b);
    endfunction

    function automatic void track_number(logic [7:0] c);
        logic digit;
        logic sign_ch;
        digit   = c >= CH_ZERO && c <= CH_NINE;
        sign_ch = c == CH_MINUS || c == CH_PLUS;
        if (!(digit || c == CH_DOT ||
              (!plain_only && (sign_ch || c == CH_LO_E || c == CH_UP_E)))) begin
            still_numeric = 1'b0;
        end else if (digit) begin
            seen_digit = 1'b1;
            digit_tail = 1'b1;
        end else if (sign_ch) begin
            digit_tail = 1'b0;
        end
    endfunction

    function automatic logic [2:0] token_end_kind();
        return (still_numeric && seen_digit && digit_tail) ? KIND_NUM : KIND_ALPHA;
    endfunction

    function automatic void idle_byte(logic [7:0] c);
        if (c == CH_NL) begin
            scan_mode = MODE_IDLE;
            emit(KIND_EOL, 8'd0);
        end else if (is_delim(c)) begin
            scan_mode = collapse_en ? MODE_RUN : MODE_IDLE;
            emit(KIND_SEP, 8'd0);
        end else if (c == CH_QUOTE) begin
            scan_mode = MODE_QUOTED;
        end else begin
            scan_mode     = MODE_TOKEN;
            still_numeric = !text_only && c != CH_LO_E && c != CH_UP_E;
            seen_digit    = 1'b0;
            digit_tail    = 1'b0;
            track_number(c);
            emit(KIND_CHAR, c);
        end
    endfunction

    // works out the results of one input transaction and queues them
    function automatic void predict_tokens(in_item_t it);
        logic [7:0] c;
        out_item_t  r;
        c = it.text_byte;
        step_res.delete();
        if (it.end_of_input) begin
            if (scan_mode == MODE_TOKEN)
                emit(token_end_kind(), 8'd0);
            else if (scan_mode == MODE_QUOTED)
                emit(KIND_ALPHA, 8'd0);
            scan_mode = MODE_IDLE;
            emit(KIND_END, 8'd0);
        end else begin
            case (scan_mode)
                MODE_TOKEN: begin
                    if (is_delim(c) || c == CH_NL) begin
                        emit(token_end_kind(), 8'd0);
                        idle_byte(c);
                    end else begin
                        track_number(c);
                        emit(KIND_CHAR, c);
                    end
                end
                MODE_QUOTED: begin
                    if (c == CH_QUOTE) begin
                        scan_mode = MODE_IDLE;
                        emit(KIND_ALPHA, 8'd0);
                    end else if (c == CH_NL) begin
                        scan_mode = MODE_IDLE;
                        emit(KIND_ALPHA, 8'd0);
                        emit(KIND_EOL, 8'd0);
                    end else begin
                        emit(KIND_CHAR, c);
                    end
                end
                MODE_RUN: begin
                    // a newline equal to a delimiter is swallowed here too
                    if (!is_delim(c))
                        idle_byte(c);
                end
                default: idle_byte(c);
            endcase
        end
        for (int i = 0; i < step_res.size(); i++) begin
            r      = step_res[i];
            r.last = (i == step_res.size() - 1);
            expected_tokens.push_back(r);
        end
    endfunction

    // sender: bursts of random length with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_taken = 1'b0;
        end else if (!s_valid || s_taken) begin
            s_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                s_data  <= pending_bytes.pop_front();
                s_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left   = (gap_max == 0 || $urandom_range(0, 3) == 0) ? 0 :
                                 $urandom_range(1, gap_max);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: ready runs broken by stalls
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (ready_left > 0) begin
            ready_left--;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            ready_left = $urandom_range(0, 12);
            stall_left = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
            m_ready <= 1'b1;
        end
    end

    // acceptance, register shadowing, result checking and watchdog
    always @(posedge aclk) begin
        out_item_t want;
        bit        moved;
        moved = 1'b0;
        if (aresetn) begin
            if (cfg_wr_en) begin
                moved = 1'b1;
                cfg_count++;
                case (cfg_addr)
                    CFG_FIRST_DELIM:  delim_a     = cfg_wdata;
                    CFG_SECOND_DELIM: delim_b     = cfg_wdata;
                    CFG_COLLAPSE:     collapse_en = cfg_wdata[0];
                    CFG_NUMS_AS_TEXT: text_only   = cfg_wdata[0];
                    CFG_PLAIN_NUMS:   plain_only  = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                moved = 1'b1;
                predict_tokens(s_data);
                in_count++;
                if (s_data.end_of_input)
                    end_count++;
                s_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                out_count++;
                if (expected_tokens.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected result kind=%0d char=%02h last=%0b",
                                 $time, m_data.kind, m_data.char_out, m_data.last);
                end else begin
                    want = expected_tokens.pop_front();
                    if (m_data.kind !== want.kind || m_data.char_out !== want.char_out ||
                        m_data.last !== want.last) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: mismatch expected kind=%0d char=%02h last=%0b,",
                                     $time, want.kind, want.char_out, want.last,
                                     " got kind=%0d char=%02h last=%0b",
                                     m_data.kind, m_data.char_out, m_data.last);
                    end
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_byte(logic [7:0] b);
        in_item_t it;
        it.text_byte    = b;
        it.end_of_input = 1'b0;
        pending_bytes.push_back(it);
    endtask

    task automatic push_end(logic [7:0] b);
        in_item_t it;
        it.text_byte    = b;
        it.end_of_input = 1'b1;
        pending_bytes.push_back(it);
    endtask

    task automatic push_delim();
        push_byte((delim_b != 8'd0 && $urandom_range(0, 1) == 1) ? delim_b : delim_a);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [7:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // holds the sender until every expected result is back and the block is quiet
    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_bytes.size() != 0 || s_valid || expected_tokens.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // fills the sender queue with records of random fields
    task automatic queue_records(int count);
        int pick;
        int n;
        while (pending_bytes.size() < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                // number, sometimes malformed
                if ($urandom_range(0, 2) == 0)
                    push_byte($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
                n = $urandom_range(0, 4);
                repeat (n) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 4) < 2) begin
                    push_byte(CH_DOT);
                    n = $urandom_range(0, 3);
                    repeat (n) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                end
                if ($urandom_range(0, 3) == 0) begin
                    push_byte($urandom_range(0, 1) ? CH_LO_E : CH_UP_E);
                    if ($urandom_range(0, 1) == 1)
                        push_byte($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
                    n = $urandom_range(0, 2);
                    repeat (n) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                end
                if ($urandom_range(0, 9) == 0)
                    push_byte($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            end else if (pick < 55) begin
                // word; a leading e makes even digits alpha
                if ($urandom_range(0, 4) == 0)
                    push_byte($urandom_range(0, 1) ? CH_LO_E : CH_UP_E);
                else
                    push_byte(8'($urandom_range(97, 122)));
                n = $urandom_range(0, 5);
                repeat (n) begin
                    case ($urandom_range(0, 7))
                        0: push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                        1: push_byte(CH_QUOTE);
                        2: push_byte(8'($urandom_range(0, 255)));
                        3: push_byte(8'($urandom_range(65, 90)));
                        default: push_byte(8'($urandom_range(97, 122)));
                    endcase
                end
            end else if (pick < 70) begin
                // quoted field, closed by a quote or cut by a newline
                push_byte(CH_QUOTE);
                n = $urandom_range(0, 5);
                repeat (n) begin
                    case ($urandom_range(0, 9))
                        0, 1: push_delim();
                        2, 3: push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                        4:    push_byte(8'($urandom_range(0, 255)));
                        default: push_byte(8'($urandom_range(97, 122)));
                    endcase
                end
                push_byte(($urandom_range(0, 4) == 0) ? CH_NL : CH_QUOTE);
            end else if (pick < 90) begin
                n = $urandom_range(1, 3);
                repeat (n) push_byte(8'($urandom_range(0, 255)));
            end
            // field terminator; an empty field falls out of pick >= 90
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
                repeat (n) push_delim();
            end else if (pick < 85) begin
                push_byte(CH_NL);
            end else if (pick < 93) begin
                push_end(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic run_phase(logic [7:0] d1, logic [7:0] d2, logic col, logic txt,
                             logic pln, int gaps, int stalls);
        write_reg(CFG_FIRST_DELIM, d1);
        write_reg(CFG_SECOND_DELIM, d2);
        write_reg(CFG_COLLAPSE, {7'd0, col});
        write_reg(CFG_NUMS_AS_TEXT, {7'd0, txt});
        write_reg(CFG_PLAIN_NUMS, {7'd0, pln});
        gap_max   = gaps;
        stall_max = stalls;
        @(posedge aclk);
        queue_records(PHASE_ITEMS);
        wait_drained();
    endtask

    initial begin
        string directed_text;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: signed exponent number, leading e, quoted field cut by
        // newline, empty quoted field, sign after last digit, quote inside a token,
        // NUL and 0xFF bytes, repeated end of input
        gap_max   = 2;
        stall_max = 2;
        directed_text = "-1.5e3,e5,\"a,\n\"\"5-,x\"\n";
        foreach (directed_text[i])
            push_byte(directed_text[i]);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_end(8'hFF);
        push_end(8'h00);
        wait_drained();

        run_phase(8'd59, 8'h09, 1'b1, 1'b0, 1'b0, 0, 0);
        run_phase(8'h00, 8'hFF, 1'b0, 1'b1, 1'b0, 4, 3);
        run_phase(8'hFF, CH_NL, 1'b1, 1'b0, 1'b1, 2, 6);
        run_phase(8'h7C, 8'd44, 1'b0, 1'b0, 1'b0, 8, 8);
        run_phase(8'h20, CH_QUOTE, 1'b1, 1'b1, 1'b1, 3, 1);
        run_phase(8'd44, 8'h00, 1'b0, 1'b0, 1'b0, 5, 5);

        if (expected_tokens.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_tokens.size());
            error_count++;
        end
        $display("Ran %0d input transactions (%0d end marks), checked %0d results",
                 in_count, end_count, out_count);
        $display("over %0d register writes in 7 settings; %0d errors", cfg_count, error_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
sv/dtt_pkg.sv
sv/dtt_scan.sv
sv/dtt_rq.sv
sv/delimited_text_tokenizer_top.sv
dv/tb.sv
